// ----- rtl/core/life_automaton_generation_assert.svh -----
// ----------------------------------------------------------------------------
// life automaton generation assertion macros
// clocked on clk, held off while rst is high
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GENERATION_ASSERT_SVH
`define LIFE_AUTOMATON_GENERATION_ASSERT_SVH

// condition holds at every edge
`define LAG_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("life automaton assertion failed");

// consequent holds whenever the antecedent does
`define LAG_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("life automaton assertion failed");

`endif

// ----- rtl/core/lag_pkg.sv -----
// ----------------------------------------------------------------------------
// lag_pkg
// grid geometry, command codes and the types shared by the life automaton
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ROW_W       = $clog2(GRID_HEIGHT);
  localparam int COL_W       = $clog2(GRID_WIDTH);
  localparam int POP_W       = 13;
  localparam int NB_W        = 4;
  localparam int NB_BIRTH    = 3;
  localparam int NB_KEEP     = 2;
  localparam int GROUP_W     = 8;
  localparam int GROUP_N     = GRID_WIDTH / GROUP_W;
  localparam int GROUP_CNT_W = $clog2(GROUP_W + 1);
  localparam int GEN_LAST    = GRID_HEIGHT + 3;
  localparam int GEN_CNT_W   = $clog2(GEN_LAST + 1);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] col;
    logic [5:0] row;
  } req_t;

  typedef struct packed {
    logic              changed;
    logic [POP_W-1:0]  population;
    logic              cell_alive;
  } rsp_t;

  typedef struct packed {
    logic             req_load;
    logic             clear_en;
    logic             gen_start;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             set_wr_en;
    logic             shift_en;
    logic             shift_zero;
    logic             gen_wr_en;
    logic [ROW_W-1:0] gen_wr_row;
    logic             rsp_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row;
  } dp_status_t;

endpackage

// ----- rtl/core/lag_ctrl.sv -----
// ----------------------------------------------------------------------------
// lag_ctrl
// command sequencer: request intake, row sweep for a generation, response
// ----------------------------------------------------------------------------
module lag_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic [1:0]            req_cmd,
  output logic                  req_stall,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output lag_pkg::ctl_cmd_t     ctl,
  input  lag_pkg::dp_status_t   status
);
  import lag_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACCESS = 3'd1;
  localparam logic [2:0] S_MODIFY = 3'd2;
  localparam logic [2:0] S_GEN    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [GEN_CNT_W-1:0] gen_cnt;
  logic [GEN_CNT_W-1:0] gen_cnt_next;
  logic                 accept;
  logic                 rsp_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    ctl          = '0;
    state_next   = state;
    gen_cnt_next = gen_cnt;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.req_load = 1'b1;
          case (req_cmd)
            CMD_CLEAR: begin
              ctl.clear_en = 1'b1;
              state_next   = S_DONE;
            end
            CMD_STEP: begin
              ctl.gen_start = 1'b1;
              gen_cnt_next  = '0;
              state_next    = S_GEN;
            end
            default: begin
              state_next = S_ACCESS;
            end
          endcase
        end
      end
      S_ACCESS: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_row = status.row[ROW_W-1:0];
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        ctl.set_wr_en = (status.cmd == CMD_SET);
        state_next    = S_DONE;
      end
      S_GEN: begin
        // read row n, shift it in the cycle after, write new row n once it reaches the middle of the window
        ctl.rd_en      = (gen_cnt < GEN_CNT_W'(GRID_HEIGHT));
        ctl.rd_row     = gen_cnt[ROW_W-1:0];
        ctl.shift_en   = (gen_cnt >= GEN_CNT_W'(1)) && (gen_cnt <= GEN_CNT_W'(GRID_HEIGHT + 2));
        ctl.shift_zero = (gen_cnt > GEN_CNT_W'(GRID_HEIGHT));
        ctl.gen_wr_en  = (gen_cnt >= GEN_CNT_W'(3)) && (gen_cnt <= GEN_CNT_W'(GRID_HEIGHT + 2));
        ctl.gen_wr_row = ROW_W'(gen_cnt - GEN_CNT_W'(3));
        if (gen_cnt == GEN_CNT_W'(GEN_LAST)) begin
          state_next = S_DONE;
        end else begin
          gen_cnt_next = gen_cnt + GEN_CNT_W'(1);
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          ctl.rsp_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gen_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      gen_cnt <= gen_cnt_next;
      if (ctl.rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/lag_dp.sv -----
// ----------------------------------------------------------------------------
// lag_dp
// grid memory, three-row window with the b3/s23 rule, population and response
// ----------------------------------------------------------------------------
module lag_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  lag_pkg::req_t         req,
  input  lag_pkg::ctl_cmd_t     ctl,
  output lag_pkg::dp_status_t   status,
  output lag_pkg::rsp_t         rsp
);
  import lag_pkg::*;

  function automatic logic [GROUP_CNT_W-1:0] pop_group(input logic [GROUP_W-1:0] bits);
    logic [GROUP_CNT_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      acc = acc + GROUP_CNT_W'(bits[i]);
    end
    return acc;
  endfunction

  logic [GRID_WIDTH-1:0]  mem [GRID_HEIGHT];
  logic                   row_valid [GRID_HEIGHT];
  req_t                   req_q;
  logic [GRID_WIDTH-1:0]  rd_data;
  logic                   rd_ok;
  logic [GRID_WIDTH-1:0]  rd_row_data;
  logic [GRID_WIDTH-1:0]  above;
  logic [GRID_WIDTH-1:0]  mid;
  logic [GRID_WIDTH-1:0]  below;
  logic [GRID_WIDTH+1:0]  pad_above;
  logic [GRID_WIDTH+1:0]  pad_mid;
  logic [GRID_WIDTH+1:0]  pad_below;
  logic [NB_W-1:0]        nb_cnt [GRID_WIDTH];
  logic [GRID_WIDTH-1:0]  new_row;
  logic [GROUP_CNT_W-1:0] grp_cnt [GROUP_N];
  logic                   grp_changed;
  logic                   a_valid;
  logic [POP_W-1:0]       grp_sum;
  logic [POP_W-1:0]       live_count;
  logic                   changed_acc;
  logic                   in_grid;
  logic                   cur_bit;
  logic [GRID_WIDTH-1:0]  set_row;
  logic                   set_do;
  rsp_t                   rsp_q;

  assign in_grid     = (32'(req_q.col) < GRID_WIDTH) && (32'(req_q.row) < GRID_HEIGHT);
  assign rd_row_data = rd_ok ? rd_data : '0;
  assign cur_bit     = rd_row_data[req_q.col[COL_W-1:0]];
  assign set_row     = rd_row_data | (GRID_WIDTH'(1) << req_q.col[COL_W-1:0]);
  assign set_do      = ctl.set_wr_en && in_grid && !cur_bit;

  // cells beyond the edges are dead
  assign pad_above = {1'b0, above, 1'b0};
  assign pad_mid   = {1'b0, mid, 1'b0};
  assign pad_below = {1'b0, below, 1'b0};

  always_comb begin
    for (int c = 0; c < GRID_WIDTH; c++) begin
      nb_cnt[c] = NB_W'(pad_above[c]) + NB_W'(pad_above[c+1]) + NB_W'(pad_above[c+2])
                + NB_W'(pad_mid[c]) + NB_W'(pad_mid[c+2])
                + NB_W'(pad_below[c]) + NB_W'(pad_below[c+1]) + NB_W'(pad_below[c+2]);
      new_row[c] = (nb_cnt[c] == NB_W'(NB_BIRTH)) || (mid[c] && (nb_cnt[c] == NB_W'(NB_KEEP)));
    end
  end

  always_comb begin
    grp_sum = '0;
    for (int g = 0; g < GROUP_N; g++) begin
      grp_sum = grp_sum + POP_W'(grp_cnt[g]);
    end
  end

  // grid memory, one write and one read port
  always_ff @(posedge clk) begin
    if (ctl.gen_wr_en) begin
      mem[ctl.gen_wr_row] <= new_row;
    end else if (set_do) begin
      mem[req_q.row[ROW_W-1:0]] <= set_row;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_row];
      rd_ok   <= row_valid[ctl.rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.req_load) begin
      req_q <= req;
    end
    if (ctl.gen_start) begin
      above <= '0;
      mid   <= '0;
      below <= '0;
    end else if (ctl.shift_en) begin
      above <= mid;
      mid   <= below;
      below <= ctl.shift_zero ? '0 : rd_row_data;
    end
    if (ctl.gen_wr_en) begin
      for (int g = 0; g < GROUP_N; g++) begin
        grp_cnt[g] <= pop_group(new_row[g*GROUP_W +: GROUP_W]);
      end
      grp_changed <= |(new_row ^ mid);
    end
    if (ctl.gen_start) begin
      changed_acc <= 1'b0;
    end else if (a_valid) begin
      changed_acc <= changed_acc | grp_changed;
    end
    if (ctl.rsp_load) begin
      rsp_q.changed    <= (req_q.cmd == CMD_STEP) && changed_acc;
      rsp_q.population <= live_count;
      rsp_q.cell_alive <= (req_q.cmd == CMD_READ) && in_grid && cur_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < GRID_HEIGHT; r++) begin
        row_valid[r] <= 1'b0;
      end
      a_valid    <= 1'b0;
      live_count <= '0;
    end else begin
      a_valid <= ctl.gen_wr_en;
      if (ctl.clear_en) begin
        for (int r = 0; r < GRID_HEIGHT; r++) begin
          row_valid[r] <= 1'b0;
        end
      end else if (ctl.gen_wr_en) begin
        row_valid[ctl.gen_wr_row] <= 1'b1;
      end else if (set_do) begin
        row_valid[req_q.row[ROW_W-1:0]] <= 1'b1;
      end
      if (ctl.clear_en || ctl.gen_start) begin
        live_count <= '0;
      end else if (a_valid) begin
        live_count <= live_count + grp_sum;
      end else if (set_do) begin
        live_count <= live_count + POP_W'(1);
      end
    end
  end

  assign status.cmd = req_q.cmd;
  assign status.row = req_q.row;
  assign rsp        = rsp_q;

endmodule

// ----- rtl/core/life_automaton_generation.sv -----
// ----------------------------------------------------------------------------
// life_automaton_generation
// b3/s23 cellular automaton on a bounded 64 by 64 grid with population count
// ----------------------------------------------------------------------------
// One request at a time. A set or a read does one grid memory read, then the
// update; a generation is a sweep that reads one grid row per cycle from the
// grid memory (one read and one write port) into a three-row window and writes
// the new row back in place, feeding a two-stage population pipeline. A
// finished response waits in an output register while the next request is
// taken. Reset and clear act at once through per-row valid bits.
module life_automaton_generation (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lag_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output lag_pkg::rsp_t   rsp
);
  import lag_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t status;

  lag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl),
    .status    (status)
  );

  lag_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .ctl    (ctl),
    .status (status),
    .rsp    (rsp)
  );

`include "life_automaton_generation_assert.svh"

  `LAG_ASSERT_IMPLIES(a_pop_bound, rsp_valid, 32'(rsp.population) <= GRID_CELLS)
  `LAG_ASSERT_IMPLIES(a_changed_step, $past(ctl.rsp_load) && rsp.changed, status.cmd == CMD_STEP)
  `LAG_ASSERT_IMPLIES(a_alive_read, $past(ctl.rsp_load) && rsp.cell_alive, status.cmd == CMD_READ)
  `LAG_ASSERT_ALWAYS(a_one_writer, !(ctl.gen_wr_en && ctl.set_wr_en))

endmodule
